@@ hw/rtl/lep_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lep_pkg
// Types, widths and codes shared by the two-particle local energy pipeline.
// ----------------------------------------------------------------------------
package lep_pkg;

	localparam int COORD_WIDTH  = 16;
	localparam int ENERGY_WIDTH = 32;
	localparam int COORD_FRAC   = 12;
	localparam int CFG_WIDTH    = 16;
	localparam int CFG_IDX_W    = 1;

	// derived datapath widths
	localparam int DXW  = COORD_WIDTH + 1;        // |difference|
	localparam int DW   = 2 * DXW + 1;            // dx^2 + dy^2
	localparam int SW   = (DW + 24 + 1) / 2;      // separation s, Q.24
	localparam int SQW  = 2 * SW;                 // radicand
	localparam int UW   = SW + 5;                 // u = 1 + alpha*s, Q.24
	localparam int QW   = 57;                     // quotients of 2^56
	localparam int PW   = 64;                     // Q.32 product width
	localparam int RND_W = 49;                    // rounded Q.16 sum

	localparam logic [CFG_WIDTH-1:0] ALPHA_RESET  = 16'd4096;
	localparam logic [CFG_WIDTH-1:0] LAMBDA_RESET = 16'd4096;

	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 1'd1;

	localparam logic signed [RND_W-1:0] EMAX =
		(49'sd1 <<< (ENERGY_WIDTH - 1)) - 49'sd1;
	localparam logic signed [RND_W-1:0] EMIN = -EMAX - 49'sd1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_COINCIDE = 2'd1,
		ST_SAT      = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] first_x;
		logic signed [COORD_WIDTH-1:0] first_y;
		logic signed [COORD_WIDTH-1:0] second_x;
		logic signed [COORD_WIDTH-1:0] second_y;
	} coord_item_t;

	typedef struct packed {
		logic signed [ENERGY_WIDTH-1:0] local_energy;
		status_t                        status;
	} energy_item_t;

endpackage
`default_nettype wire

@@ hw/rtl/local_energy_two_particle_2d_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// local_energy_two_particle_2d_top
// Local energy of two particles in a 2D harmonic trap with a pair factor,
// fully pipelined, Q4.12 positions in, saturated Q16.16 energy out.
//
//   channel | signals                         | role
//   pos     | pos_valid, pos_stall, pos_item  | positions in
//   res     | res_valid, res_stall, res_item  | energy and status out
//   cfg     | cfg_we, cfg_index, cfg_wdata    | alpha and lambda writes
//
// One transaction per cycle sustained while pos_stall stays low; the depth is
// set mostly by the bit-per-stage root and the 57-stage dividers. Reset
// clears the valid bits and loads alpha and lambda with 1.0.
// A two-entry output register/skid parts the sides; pos_stall is registered
// and rises only when both entries hold results.
// ----------------------------------------------------------------------------
module local_energy_two_particle_2d_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              pos_valid,
	output logic                                   pos_stall,
	input  wire lep_pkg::coord_item_t              pos_item,
	output logic                                   res_valid,
	input  wire logic                              res_stall,
	output lep_pkg::energy_item_t                  res_item,
	input  wire logic                              cfg_we,
	input  wire logic [lep_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [lep_pkg::CFG_WIDTH-1:0]     cfg_wdata
);

	localparam int CW  = lep_pkg::COORD_WIDTH;
	localparam int EW  = lep_pkg::ENERGY_WIDTH;
	localparam int DXW = lep_pkg::DXW;
	localparam int DW  = lep_pkg::DW;
	localparam int SW  = lep_pkg::SW;
	localparam int SQW = lep_pkg::SQW;
	localparam int UW  = lep_pkg::UW;
	localparam int QW  = lep_pkg::QW;
	localparam int PW  = lep_pkg::PW;
	localparam int AW  = lep_pkg::CFG_WIDTH;
	localparam int LAT = SW + QW + 14;

	// configuration
	logic [AW-1:0] alpha_q, lambda_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= lep_pkg::ALPHA_RESET;
			lambda_q <= lep_pkg::LAMBDA_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lep_pkg::CFG_ALPHA:  alpha_q  <= cfg_wdata;
				lep_pkg::CFG_LAMBDA: lambda_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// handshake and valid line
	logic en, acc, last_v;
	logic out_v_q, skid_v_q;
	lep_pkg::energy_item_t out_q, skid_q, res_s;

	assign en        = !skid_v_q;
	assign pos_stall = skid_v_q;
	assign acc       = pos_valid && !pos_stall;

	lep_dly #(.W(1), .N(LAT)) u_vline (
		.clk(clk), .arst_n(arst_n), .en(en), .d(acc), .q(last_v)
	);

	// front: differences, squares, radicand
	logic signed [CW:0] ddx, ddy;
	logic [DXW-1:0]     dx_s1, dy_s1;
	logic [2*DXW-1:0]   sqx_s2, sqy_s2;
	logic [DW-1:0]      dsum;
	logic [SQW-1:0]     x_s3;
	logic               z_s3;

	assign ddx  = {pos_item.first_x[CW-1], pos_item.first_x}
	            - {pos_item.second_x[CW-1], pos_item.second_x};
	assign ddy  = {pos_item.first_y[CW-1], pos_item.first_y}
	            - {pos_item.second_y[CW-1], pos_item.second_y};
	assign dsum = DW'(sqx_s2) + DW'(sqy_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= ddx[CW] ? DXW'(-ddx) : DXW'(ddx);
			dy_s1  <= ddy[CW] ? DXW'(-ddy) : DXW'(ddy);
			sqx_s2 <= (2*DXW)'(dx_s1) * (2*DXW)'(dx_s1);
			sqy_s2 <= (2*DXW)'(dy_s1) * (2*DXW)'(dy_s1);
			x_s3   <= SQW'(dsum) << 24;
			z_s3   <= (dsum == '0);
		end
	end

	// separation
	logic [SW-1:0] s_sq;
	logic          z_sq;

	lep_sqrt #(.SW(SW)) u_sqrt (.clk(clk), .en(en), .x(x_s3), .root(s_sq));
	lep_dly #(.W(1), .N(SW)) u_zsq (
		.clk(clk), .arst_n(arst_n), .en(en), .d(z_s3), .q(z_sq)
	);

	// u = 1 + alpha*s
	logic [AW+SW-1:0] au_s4;
	logic [SW-1:0]    s_s4, s_s5;
	logic             z_s4, z_s5;
	logic [UW-1:0]    u_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			au_s4 <= (AW+SW)'(alpha_q) * (AW+SW)'(s_sq);
			s_s4  <= s_sq;
			z_s4  <= z_sq;
			u_s5  <= UW'(25'h100_0000) + UW'(au_s4 >> lep_pkg::COORD_FRAC);
			s_s5  <= s_s4;
			z_s5  <= z_s4;
		end
	end

	// w = 1/u, r = 1/s
	logic [QW-1:0] wq, rq;
	logic [SW-1:0] s_dv;
	logic          z_dv;

	lep_div #(.DVW(UW), .QW(QW)) u_divw (.clk(clk), .en(en), .d(u_s5), .quo(wq));
	lep_div #(.DVW(SW), .QW(QW)) u_divr (.clk(clk), .en(en), .d(s_s5), .quo(rq));
	lep_dly #(.W(SW), .N(QW)) u_sdv (
		.clk(clk), .arst_n(arst_n), .en(en), .d(s_s5), .q(s_dv)
	);
	lep_dly #(.W(1), .N(QW)) u_zdv (
		.clk(clk), .arst_n(arst_n), .en(en), .d(z_s5), .q(z_dv)
	);

	// products, first round
	logic [PW-1:0] w64, r64, lam64, sl8;
	logic [PW-1:0] w2, lr, ls, l2q, w_m1;
	logic          z_m1;

	assign w64   = PW'(wq);
	assign r64   = PW'(rq);
	assign lam64 = PW'(lambda_q) << (32 - lep_pkg::COORD_FRAC);
	assign sl8   = PW'(s_dv) << 8;

	lep_mulq u_mw2  (.clk(clk), .en(en), .a(w64),   .b(w64),   .p(w2));
	lep_mulq u_mlr  (.clk(clk), .en(en), .a(lam64), .b(r64),   .p(lr));
	lep_mulq u_mls  (.clk(clk), .en(en), .a(lam64), .b(sl8),   .p(ls));
	lep_mulq u_ml2  (.clk(clk), .en(en), .a(lam64), .b(lam64), .p(l2q));
	lep_dly #(.W(PW), .N(2)) u_wm1 (
		.clk(clk), .arst_n(arst_n), .en(en), .d(w64), .q(w_m1)
	);
	lep_dly #(.W(1), .N(2)) u_zm1 (
		.clk(clk), .arst_n(arst_n), .en(en), .d(z_dv), .q(z_m1)
	);

	// products, second round
	logic [PW-1:0] w3, w4, t2, w2_m2, lr_m2, l2q_m2;
	logic          z_m2;

	lep_mulq u_mw3 (.clk(clk), .en(en), .a(w2), .b(w_m1), .p(w3));
	lep_mulq u_mw4 (.clk(clk), .en(en), .a(w2), .b(w2),   .p(w4));
	lep_mulq u_mt2 (.clk(clk), .en(en), .a(ls), .b(w2),   .p(t2));
	lep_dly #(.W(3*PW+1), .N(2)) u_dm2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({w2, lr, l2q, z_m1}), .q({w2_m2, lr_m2, l2q_m2, z_m2})
	);

	// f = 1 + w^2 - 2w^3
	logic [PW-1:0] f_sf, w4_sf, t2_sf, lr_sf, l2q_sf;
	logic          z_sf;

	always_ff @(posedge clk) begin
		if (en) begin
			f_sf   <= 64'h1_0000_0000 + w2_m2 - {w3[PW-2:0], 1'b0};
			w4_sf  <= w4;
			t2_sf  <= t2;
			lr_sf  <= lr_m2;
			l2q_sf <= l2q_m2;
			z_sf   <= z_m2;
		end
	end

	// products, third round
	logic [PW-1:0] t1, t3, t2_m3;
	logic          z_m3;

	lep_mulq u_mt1 (.clk(clk), .en(en), .a(lr_sf),  .b(f_sf),  .p(t1));
	lep_mulq u_mt3 (.clk(clk), .en(en), .a(l2q_sf), .b(w4_sf), .p(t3));
	lep_dly #(.W(PW+1), .N(2)) u_dm3 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({t2_sf, z_sf}), .q({t2_m3, z_m3})
	);

	// sum, round, saturate
	logic [PW-1:0]                    e_se, eb;
	logic                             z_se;
	logic signed [lep_pkg::RND_W-1:0] qv;
	lep_pkg::energy_item_t            res_n;

	always_ff @(posedge clk) begin
		if (en) begin
			e_se <= 64'h2_0000_0000 + t1 + t2_m3 - t3 + 64'd32768;
			z_se <= z_m3;
		end
	end

	assign eb = e_se + 64'h4000_0000_0000_0000;
	assign qv = $signed({1'b0, eb[63:16]}) - $signed(49'h4000_0000_0000);

	always_comb begin
		res_n.local_energy = qv[EW-1:0];
		res_n.status       = lep_pkg::ST_OK;
		if (z_se) begin
			res_n.local_energy = lep_pkg::EMAX[EW-1:0];
			res_n.status       = lep_pkg::ST_COINCIDE;
		end else if (qv > lep_pkg::EMAX) begin
			res_n.local_energy = lep_pkg::EMAX[EW-1:0];
			res_n.status       = lep_pkg::ST_SAT;
		end else if (qv < lep_pkg::EMIN) begin
			res_n.local_energy = lep_pkg::EMIN[EW-1:0];
			res_n.status       = lep_pkg::ST_SAT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) res_s <= res_n;
	end

	// output register and skid
	logic take;
	assign take = out_v_q && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take || !out_v_q) begin
			out_v_q  <= skid_v_q || (en && last_v);
			skid_v_q <= 1'b0;
		end else if (en && last_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : res_s;
		end else if (en && last_v) begin
			skid_q <= res_s;
		end
	end

	assign res_valid = out_v_q;
	assign res_item  = out_q;

endmodule
`default_nettype wire

@@ hw/rtl/lep_dly.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lep_dly
// Enabled shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module lep_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) tap_q[k] <= '0;
		end else if (en) begin
			tap_q[0] <= d;
			for (int k = 1; k < N; k++) tap_q[k] <= tap_q[k-1];
		end
	end

	assign q = tap_q[N-1];

endmodule
`default_nettype wire

@@ hw/rtl/lep_mulq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lep_mulq
// Two-stage Q.32 multiplier: floor(a*b / 2^32) mod 2^64 from four 32x32
// partial products.
// ----------------------------------------------------------------------------
module lep_mulq (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic [lep_pkg::PW-1:0]  a,
	input  wire logic [lep_pkg::PW-1:0]  b,
	output logic      [lep_pkg::PW-1:0]  p
);

	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [63:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= 64'(a[31:0])  * 64'(b[31:0]);
			lh_s1 <= 64'(a[31:0])  * 64'(b[63:32]);
			hl_s1 <= 64'(a[63:32]) * 64'(b[31:0]);
			hh_s1 <= 64'(a[63:32]) * 64'(b[63:32]);
			p_s2  <= {hh_s1[31:0], 32'd0} + lh_s1 + hl_s1 + {32'd0, ll_s1[63:32]};
		end
	end

	assign p = p_s2;

endmodule
`default_nettype wire

@@ hw/rtl/lep_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lep_sqrt
// Pipelined integer square root, one root bit per stage (remainder method).
// ----------------------------------------------------------------------------
module lep_sqrt #(
	parameter int SW = 30
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [2*SW-1:0] x,
	output logic      [SW-1:0]   root
);

	localparam int XW  = 2 * SW;
	localparam int RMW = SW + 3;

	logic [RMW-1:0] rem_s  [SW];
	logic [SW-1:0]  root_s [SW];
	logic [XW-1:0]  x_s    [SW];

	logic [RMW-1:0] rem_n  [SW];
	logic [SW-1:0]  root_n [SW];
	logic [XW-1:0]  x_n    [SW];

	always_comb begin
		logic [RMW-1:0] rem_i, cand, trial;
		logic [SW-1:0]  root_i;
		logic [XW-1:0]  x_i;
		for (int k = 0; k < SW; k++) begin
			if (k == 0) begin
				rem_i  = '0;
				root_i = '0;
				x_i    = x;
			end else begin
				rem_i  = rem_s[k-1];
				root_i = root_s[k-1];
				x_i    = x_s[k-1];
			end
			cand  = {rem_i[RMW-3:0], x_i[XW-1 -: 2]};
			trial = {1'b0, root_i, 2'b01};
			if (cand >= trial) begin
				rem_n[k]  = cand - trial;
				root_n[k] = {root_i[SW-2:0], 1'b1};
			end else begin
				rem_n[k]  = cand;
				root_n[k] = {root_i[SW-2:0], 1'b0};
			end
			x_n[k] = {x_i[XW-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SW; k++) begin
				rem_s[k]  <= rem_n[k];
				root_s[k] <= root_n[k];
				x_s[k]    <= x_n[k];
			end
		end
	end

	assign root = root_s[SW-1];

endmodule
`default_nettype wire

@@ hw/rtl/lep_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lep_div
// Pipelined restoring divider for floor(2^(QW-1) / d), one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module lep_div #(
	parameter int DVW = 35,
	parameter int QW  = 57
) (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire logic [DVW-1:0] d,
	output logic      [QW-1:0]  quo
);

	logic [DVW-1:0] rem_s [QW];
	logic [DVW-1:0] d_s   [QW];
	logic [QW-1:0]  q_s   [QW];

	logic [DVW-1:0] rem_n [QW];
	logic [QW-1:0]  q_n   [QW];

	always_comb begin
		logic [DVW-1:0] rem_i, d_i;
		logic [QW-1:0]  q_i;
		logic [DVW:0]   cand;
		for (int k = 0; k < QW; k++) begin
			if (k == 0) begin
				rem_i = '0;
				d_i   = d;
				q_i   = '0;
			end else begin
				rem_i = rem_s[k-1];
				d_i   = d_s[k-1];
				q_i   = q_s[k-1];
			end
			cand = {rem_i, (k == 0)};
			if (cand >= {1'b0, d_i}) begin
				rem_n[k] = DVW'(cand - {1'b0, d_i});
				q_n[k]   = {q_i[QW-2:0], 1'b1};
			end else begin
				rem_n[k] = cand[DVW-1:0];
				q_n[k]   = {q_i[QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_s[k] <= rem_n[k];
				q_s[k]   <= q_n[k];
				d_s[k]   <= (k == 0) ? d : d_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign quo = q_s[QW-1];

endmodule
`default_nettype wire

@@ hw/rtl/lep_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lep_chk
// Port-level checks for the local energy pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module lep_chk (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  pos_stall,
	input wire logic                  res_valid,
	input wire logic                  res_stall,
	input wire lep_pkg::energy_item_t res_item
);

	localparam int EW = lep_pkg::ENERGY_WIDTH;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_item))
		else $error("stalled result changed");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		pos_stall |-> res_valid)
		else $error("input stalled with no result waiting");

	a_coinc: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.status == lep_pkg::ST_COINCIDE
		|-> res_item.local_energy == lep_pkg::EMAX[EW-1:0])
		else $error("coincident result not at positive rail");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.status == lep_pkg::ST_SAT
		|-> res_item.local_energy == lep_pkg::EMAX[EW-1:0]
		 || res_item.local_energy == lep_pkg::EMIN[EW-1:0])
		else $error("saturated result not at a rail");

endmodule

bind local_energy_two_particle_2d_top lep_chk u_lep_chk (
	.clk(clk),
	.arst_n(arst_n),
	.pos_stall(pos_stall),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_item(res_item)
);
`default_nettype wire
